/* src/prov_pkg.sv */
// ============================================================================
// prov_pkg
// Shared types and constants of the power resource owner voting block.
// ============================================================================
package prov_pkg;

    localparam int MAX_OWNERS_DEF = 8;
    localparam int OWNER_W        = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [OWNER_W-1:0]   OWNER_NONE  = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND = 2'd1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_STATUS  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        RC_OK        = 3'd0,
        RC_BAD_OWNER = 3'd1,
        RC_NOT_INIT  = 3'd2,
        RC_NOT_FOUND = 3'd3,
        RC_ALREADY   = 3'd4,
        RC_FULL      = 3'd5,
        RC_BUSY      = 3'd6,
        RC_SWITCH    = 3'd7
    } t_result;

    typedef enum logic [1:0] {
        PS_OFF = 2'd0,
        PS_ON  = 2'd1,
        PS_ERR = 2'd2
    } t_power;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_MOVE
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic [7:0]         requested_id;
        logic [OWNER_W-1:0] owner_id;
        logic [3:0]         switch_error;
    } t_req;

    typedef struct packed {
        t_result    result_code;
        logic [3:0] error_detail;
        t_power     power_state;
        logic [3:0] owner_count;
        logic [3:0] rec_error;
    } t_rsp;

    typedef struct packed {
        logic [7:0] res_id;
        logic       backend;
    } t_cfg;

endpackage

/* src/prov_ram.sv */
// ============================================================================
// prov_ram
// Generic single write port RAM with one registered read port.
// ============================================================================
module prov_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/prov_ctrl.sv */
// ============================================================================
// prov_ctrl
// Request sequencer: checks, owner table scan with one comparator, update.
// ============================================================================
module prov_ctrl #(
    parameter int MAX_OWNERS = prov_pkg::MAX_OWNERS_DEF,
    localparam int AW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1,
    localparam int CW = $clog2(MAX_OWNERS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  prov_pkg::t_req               i_req,
    input  prov_pkg::t_cfg               i_cfg,
    input  logic [prov_pkg::OWNER_W-1:0] i_rd_data,
    output logic                         o_busy,
    output logic                         o_done,
    output prov_pkg::t_rsp               o_rsp,
    output logic                         o_ram_we,
    output logic [AW-1:0]                o_ram_waddr,
    output logic [prov_pkg::OWNER_W-1:0] o_ram_wdata,
    output logic [AW-1:0]                o_ram_raddr
);

    import prov_pkg::*;

    t_state        r_state, n_state;
    logic          r_init, n_init;
    t_power        r_pwr, n_pwr;
    logic [CW-1:0] r_count, n_count;
    logic [3:0]    r_rec, n_rec;
    t_req          r_req, n_req;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic [AW-1:0] r_slot, n_slot;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    logic          fin;
    t_result       rc;
    logic [3:0]    det;
    logic          exists;
    logic          hit;
    logic [CW-1:0] cnt_m1;

    assign exists = i_cfg.backend && (i_req.requested_id == i_cfg.res_id);
    assign hit    = r_pend && (i_rd_data == r_req.owner_id);
    assign cnt_m1 = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_init  <= 1'b0;
            r_pwr   <= PS_OFF;
            r_count <= '0;
            r_rec   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_pwr   <= n_pwr;
            r_count <= n_count;
            r_rec   <= n_rec;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_rsp      <= n_rsp;
    end

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_pwr       = r_pwr;
        n_count     = r_count;
        n_rec       = r_rec;
        n_req       = r_req;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_slot      = r_slot;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        fin         = 1'b0;
        rc          = RC_OK;
        det         = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = r_req.owner_id;
        o_ram_raddr = r_idx[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    case (i_req.opcode)
                        OP_INIT: begin
                            fin = 1'b1;
                            if (r_init) begin
                                rc = RC_ALREADY;
                            end else if (i_cfg.backend) begin
                                n_count = '0;
                                n_rec   = '0;
                                if (i_req.switch_error != 4'd0) begin
                                    n_pwr = PS_ERR;
                                    n_rec = i_req.switch_error;
                                    rc    = RC_SWITCH;
                                    det   = i_req.switch_error;
                                end else begin
                                    n_pwr  = PS_OFF;
                                    n_init = 1'b1;
                                end
                            end else begin
                                n_init = 1'b1;
                            end
                        end
                        OP_STATUS: begin
                            fin = 1'b1;
                            if (!r_init) begin
                                rc = RC_NOT_INIT;
                            end else if (!exists) begin
                                rc = RC_NOT_FOUND;
                            end
                        end
                        OP_ACQUIRE, OP_RELEASE: begin
                            if (i_req.owner_id == OWNER_NONE) begin
                                fin = 1'b1;
                                rc  = RC_BAD_OWNER;
                            end else if (!r_init) begin
                                fin = 1'b1;
                                rc  = RC_NOT_INIT;
                            end else if (!exists) begin
                                fin = 1'b1;
                                rc  = RC_NOT_FOUND;
                            end else if (i_req.opcode == OP_RELEASE && r_count == '0) begin
                                fin = 1'b1;
                                rc  = RC_ALREADY;
                            end else begin
                                n_state = ST_SCAN;
                                n_idx   = '0;
                                n_pend  = 1'b0;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_req.opcode == OP_ACQUIRE) begin
                        fin = 1'b1;
                        rc  = RC_ALREADY;
                    end else if (r_count == CW'(1)) begin
                        fin = 1'b1;
                        if (r_req.switch_error != 4'd0) begin
                            n_pwr = PS_ERR;
                            n_rec = r_req.switch_error;
                            rc    = RC_SWITCH;
                            det   = r_req.switch_error;
                        end else begin
                            n_pwr   = PS_OFF;
                            n_rec   = '0;
                            n_count = '0;
                        end
                    end else begin
                        n_slot  = r_pend_idx;
                        n_state = ST_FETCH;
                    end
                end else if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + CW'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    // owner absent from the table
                    fin = 1'b1;
                    if (r_req.opcode == OP_RELEASE) begin
                        rc = RC_NOT_FOUND;
                    end else if (r_count == CW'(MAX_OWNERS)) begin
                        rc = RC_FULL;
                    end else if (r_pwr == PS_ERR && r_count != '0) begin
                        if (r_rec != 4'd0) begin
                            rc  = RC_SWITCH;
                            det = r_rec;
                        end else begin
                            rc = RC_BUSY;
                        end
                    end else if (r_count == '0 && r_req.switch_error != 4'd0) begin
                        n_pwr = PS_ERR;
                        n_rec = r_req.switch_error;
                        rc    = RC_SWITCH;
                        det   = r_req.switch_error;
                    end else begin
                        if (r_count == '0) begin
                            n_pwr = PS_ON;
                            n_rec = '0;
                        end
                        o_ram_we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
            end

            ST_FETCH: begin
                o_ram_raddr = cnt_m1[AW-1:0];
                n_state     = ST_MOVE;
            end

            ST_MOVE: begin
                // last owner moves into the freed slot
                o_ram_we    = 1'b1;
                o_ram_waddr = r_slot;
                o_ram_wdata = i_rd_data;
                n_count     = cnt_m1;
                fin         = 1'b1;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            n_state           = ST_IDLE;
            n_done            = 1'b1;
            n_rsp.result_code = rc;
            n_rsp.error_detail = det;
            n_rsp.power_state = n_pwr;
            n_rsp.owner_count = 4'(n_count);
            n_rsp.rec_error   = n_rec;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* src/power_resource_owner_voting.sv */
// ============================================================================
// power_resource_owner_voting
// Reference counted owner set of one switchable power resource.
// ============================================================================
// A request is taken when start is high and busy is low; its single result
// shows on o_rsp with o_done high for exactly one cycle, one cycle after the
// request's work ends, and must be taken then. Init and status query finish in
// the idle state. Acquire and release walk the owner table with one comparator,
// reading one entry per cycle from the table RAM; a release that leaves other
// owners then reads the last owner and moves it into the freed slot. busy is
// low again in the cycle the result is shown, so the next request may be given
// then.
module power_resource_owner_voting #(
    parameter int MAX_OWNERS = prov_pkg::MAX_OWNERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  prov_pkg::t_req                 i_req,
    output logic                           o_done,
    output prov_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [prov_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [prov_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import prov_pkg::*;

    localparam int AW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;

    logic [7:0]         r_res_id;
    logic               r_backend;
    t_cfg               cfg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [OWNER_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [OWNER_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_id  <= '0;
            r_backend <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RES_ID:  r_res_id  <= i_cfg_data[7:0];
                CFG_BACKEND: r_backend <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.res_id  = r_res_id;
    assign cfg.backend = r_backend;

    prov_ctrl #(
        .MAX_OWNERS(MAX_OWNERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_cfg      (cfg),
        .i_rd_data  (ram_rdata),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_raddr(ram_raddr)
    );

    prov_ram #(
        .WIDTH(OWNER_W),
        .DEPTH(MAX_OWNERS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule

/* src/prov_checker.sv */
// ============================================================================
// prov_checker
// Port level checks of the power resource owner voting block.
// ============================================================================
module prov_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input prov_pkg::t_req                  i_req,
    input logic                            o_done,
    input prov_pkg::t_rsp                  o_rsp
);

    import prov_pkg::*;

    logic accepted;
    assign accepted = start && !busy;

    // result shown only once the block is free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // status query answers in the next cycle
    a_status_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accepted && i_req.opcode == OP_STATUS) |=> o_done)
        else $error("status query not answered in one cycle");

    // every accepted request is answered at once or keeps the block busy
    a_request_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |=> (o_done || busy))
        else $error("request dropped");

    // detail only with a switch error, and then never zero
    a_detail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.result_code == RC_SWITCH) == (o_rsp.error_detail != 4'd0)))
        else $error("error detail inconsistent with result");

endmodule

bind power_resource_owner_voting prov_checker u_prov_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench of the power resource owner voting block.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, bad owners, a missing resource, failed
// init and switch attempts, the no-backend init, a full table and the swap on
// release. A random stream of acquire, release, status and init requests with
// an owner pool larger than the table follows, under several register
// settings. Each result is compared, field by field, with the expected value
// of its table row where one is given, or else with a local model of the owner set.
// ============================================================================
module tb_top;
    import prov_pkg::*;

    localparam int N_OWNERS    = MAX_OWNERS_DEF;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [OWNER_W-1:0] OWNER_POOL [12] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd17, 8'd64, 8'd128, 8'd200, 8'd253, 8'd254
    };

    typedef enum logic {
        RK_REQ,
        RK_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_req                   req;
        logic                   has_exp;
        t_rsp                   exp;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_req                   i_req;
    logic                   o_done;
    t_rsp                   o_rsp;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // owner set as the block should hold it
    logic                   m_ready;
    t_power                 m_power;
    logic [OWNER_W-1:0]     m_table [N_OWNERS];
    logic [3:0]             m_count;
    logic [3:0]             m_err;
    logic [7:0]             m_res_id;
    logic                   m_backend;

    t_rsp                   pending_rsp [$];
    t_row                   plan [$];
    logic                   drv_chk;
    t_rsp                   drv_want;

    int                     n_requests;
    int                     n_results;
    int                     n_cfg;
    int                     n_fail;
    int                     cycles;
    int                     rc_seen [8];

    power_resource_owner_voting #(
        .MAX_OWNERS (N_OWNERS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void power_fault(input logic [3:0] code);
        m_power = PS_ERR;
        m_err   = code;
    endfunction

    function automatic t_rsp vote_outcome(input t_req r);
        t_rsp o;
        int   slot;
        int   i;
        logic present;
        o       = '0;
        slot    = -1;
        present = m_backend && (r.requested_id == m_res_id);
        for (i = 0; i < int'(m_count); i++) begin
            if (slot < 0 && m_table[i] == r.owner_id) slot = i;
        end
        case (r.opcode)
            OP_INIT: begin
                if (m_ready) begin
                    o.result_code = RC_ALREADY;
                end else if (m_backend) begin
                    for (i = 0; i < N_OWNERS; i++) m_table[i] = OWNER_NONE;
                    m_count = '0;
                    m_err   = '0;
                    if (r.switch_error != 4'd0) begin
                        power_fault(r.switch_error);
                        o.result_code  = RC_SWITCH;
                        o.error_detail = r.switch_error;
                    end else begin
                        m_power = PS_OFF;
                        m_ready = 1'b1;
                    end
                end else begin
                    m_ready = 1'b1;
                end
            end
            OP_STATUS: begin
                if (!m_ready) o.result_code = RC_NOT_INIT;
                else if (!present) o.result_code = RC_NOT_FOUND;
            end
            default: begin
                if (r.owner_id == OWNER_NONE) begin
                    o.result_code = RC_BAD_OWNER;
                end else if (!m_ready) begin
                    o.result_code = RC_NOT_INIT;
                end else if (!present) begin
                    o.result_code = RC_NOT_FOUND;
                end else if (r.opcode == OP_ACQUIRE) begin
                    if (slot >= 0) begin
                        o.result_code = RC_ALREADY;
                    end else if (int'(m_count) >= N_OWNERS) begin
                        o.result_code = RC_FULL;
                    end else if (m_power == PS_ERR && m_count != 4'd0) begin
                        if (m_err != 4'd0) begin
                            o.result_code  = RC_SWITCH;
                            o.error_detail = m_err;
                        end else begin
                            o.result_code = RC_BUSY;
                        end
                    end else if (m_count == 4'd0 && r.switch_error != 4'd0) begin
                        power_fault(r.switch_error);
                        o.result_code  = RC_SWITCH;
                        o.error_detail = r.switch_error;
                    end else begin
                        if (m_count == 4'd0) begin
                            m_power = PS_ON;
                            m_err   = '0;
                        end
                        m_table[m_count] = r.owner_id;
                        m_count          = m_count + 4'd1;
                    end
                end else begin
                    if (m_count == 4'd0) begin
                        o.result_code = RC_ALREADY;
                    end else if (slot < 0) begin
                        o.result_code = RC_NOT_FOUND;
                    end else if (m_count == 4'd1 && r.switch_error != 4'd0) begin
                        power_fault(r.switch_error);
                        o.result_code  = RC_SWITCH;
                        o.error_detail = r.switch_error;
                    end else begin
                        if (m_count == 4'd1) begin
                            m_power = PS_OFF;
                            m_err   = '0;
                        end
                        m_count          = m_count - 4'd1;
                        m_table[slot]    = m_table[m_count];
                        m_table[m_count] = OWNER_NONE;
                    end
                end
            end
        endcase
        o.power_state = m_power;
        o.owner_count = m_count;
        o.rec_error   = m_err;
        return o;
    endfunction

    // results are compared before the request of the same edge is modelled
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                n_results++;
                if (pending_rsp.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (!$isunknown(o_rsp.result_code)) rc_seen[o_rsp.result_code]++;
                    if (o_rsp.result_code !== want.result_code) begin
                        $error("result_code: expected %0d, got %0d",
                               want.result_code, o_rsp.result_code);
                        n_fail++;
                    end
                    if (o_rsp.error_detail !== want.error_detail) begin
                        $error("error_detail: expected %0d, got %0d",
                               want.error_detail, o_rsp.error_detail);
                        n_fail++;
                    end
                    if (o_rsp.power_state !== want.power_state) begin
                        $error("power_state: expected %0d, got %0d",
                               want.power_state, o_rsp.power_state);
                        n_fail++;
                    end
                    if (o_rsp.owner_count !== want.owner_count) begin
                        $error("owner_count: expected %0d, got %0d",
                               want.owner_count, o_rsp.owner_count);
                        n_fail++;
                    end
                    if (o_rsp.rec_error !== want.rec_error) begin
                        $error("rec_error: expected %0d, got %0d",
                               want.rec_error, o_rsp.rec_error);
                        n_fail++;
                    end
                end
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_RES_ID:  m_res_id = i_cfg_data;
                    CFG_BACKEND: m_backend = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && busy === 1'b0) begin
                want = vote_outcome(i_req);
                if (drv_chk) want = drv_want;
                pending_rsp.push_back(want);
                n_requests++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_rsp.size());
            $display("power_resource_owner_voting test failed");
            $finish;
        end
    end

    function automatic void row_req(input t_opcode op, input logic [7:0] rid,
                                    input logic [7:0] own, input logic [3:0] sw);
        t_row r;
        r         = '{kind: RK_REQ, req: '0, has_exp: 1'b0, exp: '0, idx: '0, data: '0};
        r.req     = '{op, rid, own, sw};
        plan.push_back(r);
    endfunction

    function automatic void row_chk(input t_opcode op, input logic [7:0] rid,
                                    input logic [7:0] own, input logic [3:0] sw,
                                    input t_result rc, input logic [3:0] det,
                                    input t_power ps, input logic [3:0] cnt,
                                    input logic [3:0] err);
        t_row r;
        r         = '{kind: RK_REQ, req: '0, has_exp: 1'b1, exp: '0, idx: '0, data: '0};
        r.req     = '{op, rid, own, sw};
        r.exp     = '{rc, det, ps, cnt, err};
        plan.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '{kind: RK_CFG, req: '0, has_exp: 1'b0, exp: '0, idx: idx, data: data};
        plan.push_back(r);
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   p;
        p = $urandom_range(0, 99);
        if (p < 3) r.opcode = OP_INIT;
        else if (p < 45) r.opcode = OP_ACQUIRE;
        else if (p < 88) r.opcode = OP_RELEASE;
        else r.opcode = OP_STATUS;
        r.requested_id = ($urandom_range(0, 99) < 92) ? m_res_id : 8'($urandom_range(0, 255));
        p = $urandom_range(0, 99);
        if (p < 4) r.owner_id = OWNER_NONE;
        else if (p < 88) r.owner_id = OWNER_POOL[$urandom_range(0, 11)];
        else r.owner_id = 8'($urandom_range(0, 254));
        r.switch_error = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(1, 15)) : 4'd0;
        return r;
    endfunction

    task automatic issue_request(input t_req r, input logic chk, input t_rsp want);
        @(negedge i_clk);
        i_req    = r;
        drv_chk  = chk;
        drv_want = want;
        start    = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        n_cfg++;
    endtask

    initial begin
        int   ph;
        int   k;
        int   pause_at;
        logic calm;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        drv_chk    = 1'b0;
        drv_want   = '0;
        n_requests = 0;
        n_results  = 0;
        n_cfg      = 0;
        n_fail     = 0;
        cycles     = 0;
        for (k = 0; k < 8; k++) rc_seen[k] = 0;
        m_ready    = 1'b0;
        m_power    = PS_OFF;
        for (k = 0; k < N_OWNERS; k++) m_table[k] = OWNER_NONE;
        m_count    = '0;
        m_err      = '0;
        m_res_id   = '0;
        m_backend  = 1'b1;

        // reset state, ordering of checks, failed and no-backend init
        row_cfg(CFG_RES_ID, 8'h00);
        row_chk(OP_STATUS,  8'd0, 8'd0,   4'd0, RC_NOT_INIT,  4'd0, PS_OFF, 4'd0, 4'd0);
        row_chk(OP_ACQUIRE, 8'd0, 8'd255, 4'd0, RC_BAD_OWNER, 4'd0, PS_OFF, 4'd0, 4'd0);
        row_chk(OP_RELEASE, 8'd0, 8'd7,   4'd0, RC_NOT_INIT,  4'd0, PS_OFF, 4'd0, 4'd0);
        row_chk(OP_INIT,    8'd0, 8'd0,   4'd9, RC_SWITCH,    4'd9, PS_ERR, 4'd0, 4'd9);
        row_cfg(CFG_BACKEND, 8'hFE);
        row_chk(OP_ACQUIRE, 8'd0, 8'd0,   4'd0, RC_NOT_INIT,  4'd0, PS_ERR, 4'd0, 4'd9);
        row_chk(OP_INIT,    8'd0, 8'd0,   4'd6, RC_OK,        4'd0, PS_ERR, 4'd0, 4'd9);
        row_chk(OP_STATUS,  8'd0, 8'd0,   4'd0, RC_NOT_FOUND, 4'd0, PS_ERR, 4'd0, 4'd9);
        row_cfg(CFG_BACKEND, 8'h01);
        row_cfg(CFG_RES_ID, 8'hFF);
        row_chk(OP_INIT,    8'd0,   8'd0, 4'd0,  RC_ALREADY,   4'd0,  PS_ERR, 4'd0, 4'd9);
        row_chk(OP_STATUS,  8'd0,   8'd0, 4'd0,  RC_NOT_FOUND, 4'd0,  PS_ERR, 4'd0, 4'd9);
        // switch on and off, with failures on the first and last owner
        row_chk(OP_ACQUIRE, 8'd255, 8'd0, 4'd15, RC_SWITCH,    4'd15, PS_ERR, 4'd0, 4'd15);
        row_chk(OP_ACQUIRE, 8'd255, 8'd0, 4'd0,  RC_OK,        4'd0,  PS_ON,  4'd1, 4'd0);
        row_chk(OP_RELEASE, 8'd255, 8'd0, 4'd3,  RC_SWITCH,    4'd3,  PS_ERR, 4'd1, 4'd3);
        row_chk(OP_ACQUIRE, 8'd255, 8'd1, 4'd0,  RC_SWITCH,    4'd3,  PS_ERR, 4'd1, 4'd3);
        row_chk(OP_RELEASE, 8'd255, 8'd0, 4'd0,  RC_OK,        4'd0,  PS_OFF, 4'd0, 4'd0);
        row_chk(OP_ACQUIRE, 8'd255, 8'd254, 4'd0, RC_OK,       4'd0,  PS_ON,  4'd1, 4'd0);
        // fill the table, then release from the middle
        for (k = 0; k < 7; k++) row_req(OP_ACQUIRE, 8'd255, 8'(k), 4'(k * 5));
        row_chk(OP_ACQUIRE, 8'd255, 8'd200, 4'd0, RC_FULL, 4'd0, PS_ON, 4'd8, 4'd0);
        row_req(OP_RELEASE, 8'd255, 8'd2, 4'd0);
        row_chk(OP_STATUS,  8'd255, 8'd0, 4'd0, RC_OK, 4'd0, PS_ON, 4'd7, 4'd0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == RK_CFG) write_reg(plan[k].idx, plan[k].data);
            else issue_request(plan[k].req, plan[k].has_exp, plan[k].exp);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_RES_ID, (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 :
                      8'($urandom_range(0, 255)));
            write_reg(CFG_BACKEND, {7'($urandom), 1'(ph != 3)});
            write_reg(ph[0] ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
            calm     = (ph == 2);
            pause_at = $urandom_range(40, 160);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == pause_at) settle();
                issue_request(random_request(), 1'b0, '0);
                if (!calm && $urandom_range(0, 99) < 19) hold_off($urandom_range(1, 12));
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("%0d requests under %0d register writes, %0d results compared, %0d mismatches",
                 n_requests, n_cfg, n_results, n_fail);
        $display("outcomes: ok %0d, bad owner %0d, not init %0d, not found %0d, already %0d, %s",
                 rc_seen[RC_OK], rc_seen[RC_BAD_OWNER], rc_seen[RC_NOT_INIT],
                 rc_seen[RC_NOT_FOUND], rc_seen[RC_ALREADY],
                 $sformatf("full %0d, busy %0d, switch fault %0d",
                           rc_seen[RC_FULL], rc_seen[RC_BUSY], rc_seen[RC_SWITCH]));
        if (n_fail == 0 && pending_rsp.size() == 0) begin
            $display("power_resource_owner_voting test passed");
        end else begin
            $display("power_resource_owner_voting test failed");
        end
        $finish;
    end

endmodule
